@@ rtl/lgs_pkg.sv @@
// Shared types, codes and sizes for the toroidal life grid block.
package lgs_pkg;

  // Default grid bounds.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Fixed field widths of the request and configuration ports.
  localparam int MODE_W    = 2;
  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Value of both size registers after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_STEP,
    ST_RESP
  } state_t;

  // Three vertically stacked cells of one column held by a column cell.
  typedef struct packed {
    logic prev;
    logic cur;
    logic nxt;
  } win_t;

endpackage

@@ rtl/lgs_cell.sv @@
// One column cell: a three-row window column and the B3/S23 rule for its center.
module lgs_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          shift_bit,
  input  lgs_pkg::win_t left,
  input  lgs_pkg::win_t right,
  output lgs_pkg::win_t win,
  output logic          next_bit
);

  logic [3:0] count;

  // The window moves down by one row whenever a new row is shifted in.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win.prev <= win.cur;
      win.cur  <= win.nxt;
      win.nxt  <= shift_bit;
    end
  end

  always_comb begin
    count = 4'(left.prev) + 4'(left.cur) + 4'(left.nxt)
          + 4'(right.prev) + 4'(right.cur) + 4'(right.nxt)
          + 4'(win.prev) + 4'(win.nxt);
    next_bit = (count == 4'd3) || (win.cur && (count == 4'd2));
  end

endmodule

@@ rtl/life_grid_generation_step.sv @@
// Toroidal B3/S23 life grid: row memory, a chain of column cells and the controller.
// A toggle or read request passes through the access state to the response state, an
// unknown mode goes straight to the response state, and a step runs the step state first.
// Throughput: one request at a time; the next request is taken in the cycle after the
// response is loaded. Reset: synchronous; the grid is cleared row by row while requests
// are stalled, and both size registers return to 64.
module life_grid_generation_step #(
  parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  // Request channel.
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [lgs_pkg::MODE_W-1:0]   mode,
  input  logic [lgs_pkg::COL_W-1:0]    col,
  input  logic [lgs_pkg::ROW_W-1:0]    row,
  // Response channel.
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         cell_value,
  // Configuration write port.
  input  logic                         cfg_write,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CI_W  = $clog2(MAX_WIDTH);
  localparam int RA_W  = $clog2(MAX_HEIGHT);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = $clog2(MAX_HEIGHT + 4);

  // Size registers and their clamped values.
  logic [lgs_pkg::CFG_W-1:0] width_in_use;
  logic [lgs_pkg::CFG_W-1:0] height_in_use;
  logic [W_W-1:0]            w_eff;
  logic [H_W-1:0]            h_eff;

  // Controller.
  lgs_pkg::state_t state;
  lgs_pkg::state_t state_next;
  logic [RA_W-1:0]  clr_addr;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] h_cnt;
  logic [CNT_W-1:0] cnt_shift_last;
  logic [CNT_W-1:0] cnt_last;

  // Latched request.
  logic [lgs_pkg::MODE_W-1:0] req_mode;
  logic [CI_W-1:0]            req_col;
  logic [RA_W-1:0]            req_row;
  logic                       req_hit;
  logic                       resp_bit;
  logic                       access_result;
  logic                       load_rsp;

  // Row memory and its ports.
  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data;
  logic [RA_W-1:0]      rd_addr;
  logic                 wr_en;
  logic [RA_W-1:0]      wr_addr;
  logic [MAX_WIDTH-1:0] wr_data;
  logic [MAX_WIDTH-1:0] toggled_row;

  // Cell chain.
  logic [MAX_WIDTH-1:0] row0;
  logic                 save_row0;
  logic                 shift_en;
  logic                 use_saved;
  logic [MAX_WIDTH-1:0] shift_row;
  logic [MAX_WIDTH-1:0] cell_next;
  logic [MAX_WIDTH-1:0] merged_row;
  lgs_pkg::win_t        win_arr [MAX_WIDTH];
  lgs_pkg::win_t        edge_last;
  logic [CI_W-1:0]      w_last;

  // A size of zero acts as one, and a size beyond the grid acts as the grid bound.
  always_comb begin
    if (width_in_use == '0) begin
      w_eff = W_W'(1);
    end else if (int'(width_in_use) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(width_in_use);
    end
    if (height_in_use == '0) begin
      h_eff = H_W'(1);
    end else if (int'(height_in_use) > MAX_HEIGHT) begin
      h_eff = H_W'(MAX_HEIGHT);
    end else begin
      h_eff = H_W'(height_in_use);
    end
  end

  // A step runs a counter cnt through the step state. In cycle cnt the memory reads
  // row height-1 first and then rows 0 to height-1; each row reaches the cells in the
  // next cycle and is shifted into the column windows. After the reads, the saved
  // copy of old row 0 is shifted in as the row below the last one, so the last row
  // wraps onto row 0 as it was before it was overwritten. Once the window holds
  // three rows, the new center row is written back in the cycle after each shift.
  assign h_cnt          = CNT_W'(h_eff);
  assign cnt_shift_last = h_cnt + CNT_W'(2);
  assign cnt_last       = h_cnt + CNT_W'(3);

  // The column wrap: column 0 sees the last active column on its left, and the last
  // active column sees column 0 on its right.
  assign w_last    = CI_W'(w_eff - W_W'(1));
  assign edge_last = win_arr[w_last];
  assign shift_row = use_saved ? row0 : rd_data;

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    lgs_pkg::win_t left;
    lgs_pkg::win_t right;

    if (c == 0) begin : g_left_wrap
      assign left = edge_last;
    end else begin : g_left
      assign left = win_arr[c-1];
    end

    if (c == MAX_WIDTH - 1) begin : g_right_wrap
      assign right = win_arr[0];
    end else begin : g_right
      assign right = (int'(w_eff) == c + 1) ? win_arr[0] : win_arr[c+1];
    end

    lgs_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .shift_bit (shift_row[c]),
      .left      (left),
      .right     (right),
      .win       (win_arr[c]),
      .next_bit  (cell_next[c])
    );

    // Columns outside the active area keep their old contents.
    assign merged_row[c] = (c < int'(w_eff)) ? cell_next[c] : win_arr[c].cur;
  end

  // A toggle inside the active area writes back the row it read with one bit flipped; a
  // toggle returns the new value and a read the stored one, both only inside the active area.
  assign toggled_row = rd_data ^ (MAX_WIDTH'(1) << req_col);

  always_comb begin
    case (req_mode)
      lgs_pkg::MODE_TOGGLE: access_result = req_hit & ~rd_data[req_col];
      lgs_pkg::MODE_READ:   access_result = req_hit & rd_data[req_col];
      default:              access_result = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lgs_pkg::ST_CLEAR: begin
        if (clr_addr == RA_W'(MAX_HEIGHT - 1)) begin
          state_next = lgs_pkg::ST_IDLE;
        end
      end
      lgs_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (mode) inside
            lgs_pkg::MODE_STEP:                      state_next = lgs_pkg::ST_STEP;
            lgs_pkg::MODE_TOGGLE, lgs_pkg::MODE_READ: state_next = lgs_pkg::ST_ACCESS;
            default:                                 state_next = lgs_pkg::ST_RESP;
          endcase
        end
      end
      lgs_pkg::ST_ACCESS: state_next = lgs_pkg::ST_RESP;
      lgs_pkg::ST_STEP: begin
        if (cnt == cnt_last) begin
          state_next = lgs_pkg::ST_RESP;
        end
      end
      lgs_pkg::ST_RESP: begin
        if (load_rsp) begin
          state_next = lgs_pkg::ST_IDLE;
        end
      end
      default: state_next = lgs_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req_stall = 1'b1;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    shift_en  = 1'b0;
    use_saved = 1'b0;
    save_row0 = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      lgs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      lgs_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        rd_addr   = RA_W'(row);
      end
      lgs_pkg::ST_ACCESS: begin
        wr_en   = req_hit && (req_mode == lgs_pkg::MODE_TOGGLE);
        wr_addr = req_row;
        wr_data = toggled_row;
      end
      lgs_pkg::ST_STEP: begin
        rd_addr   = (cnt == '0) ? RA_W'(h_eff - H_W'(1)) : RA_W'(cnt - CNT_W'(1));
        shift_en  = (cnt != '0) && (cnt <= cnt_shift_last);
        use_saved = (cnt == cnt_shift_last);
        save_row0 = (cnt == CNT_W'(2));
        wr_en     = (cnt >= CNT_W'(4));
        wr_addr   = RA_W'(cnt - CNT_W'(4));
        wr_data   = merged_row;
      end
      lgs_pkg::ST_RESP: begin
        load_rsp = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lgs_pkg::ST_CLEAR;
      clr_addr      <= '0;
      cnt           <= '0;
      rsp_valid     <= 1'b0;
      width_in_use  <= lgs_pkg::CFG_RESET;
      height_in_use <= lgs_pkg::CFG_RESET;
    end else begin
      state <= state_next;
      if (state == lgs_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + RA_W'(1);
      end
      if (state == lgs_pkg::ST_STEP) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          lgs_pkg::CFG_WIDTH:  width_in_use  <= cfg_data;
          lgs_pkg::CFG_HEIGHT: height_in_use <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == lgs_pkg::ST_IDLE && req_valid) begin
      req_mode <= mode;
      req_col  <= CI_W'(col);
      req_row  <= RA_W'(row);
      req_hit  <= (int'(col) < int'(w_eff)) && (int'(row) < int'(h_eff));
    end
    if (state == lgs_pkg::ST_ACCESS) begin
      resp_bit <= access_result;
    end else if (state != lgs_pkg::ST_RESP) begin
      resp_bit <= 1'b0;
    end
    if (load_rsp) begin
      cell_value <= resp_bit;
    end
    if (save_row0) begin
      row0 <= rd_data;
    end
  end

  // Row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  // A response only appears after the controller has passed through its response state.
  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == lgs_pkg::ST_RESP)
    else $error("response raised outside the response state");

  // An accepted request always moves the controller out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == lgs_pkg::ST_IDLE && req_valid) |=> state != lgs_pkg::ST_IDLE)
    else $error("accepted request left the controller idle");

  // The end of a step goes to the response state with a zero result.
  a_step_result_zero: assert property (@(posedge clk) disable iff (rst)
    (state == lgs_pkg::ST_STEP && cnt == cnt_last)
      |=> (state == lgs_pkg::ST_RESP && resp_bit == 1'b0))
    else $error("step did not end with a zero response");

  // Step write-back stays inside the active rows.
  a_step_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == lgs_pkg::ST_STEP && wr_en) |-> int'(wr_addr) < int'(h_eff))
    else $error("step wrote a row outside the active area");
`endif

endmodule

@@ sim/life_grid_checker.sv @@
// Checker for the life grid block: mirrors the grid, predicts every response and compares it.
module life_grid_checker #(
  parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [lgs_pkg::MODE_W-1:0]    mode,
  input  logic [lgs_pkg::COL_W-1:0]     col,
  input  logic [lgs_pkg::ROW_W-1:0]     row,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic                          cell_value,
  input  logic                          cfg_write,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [lgs_pkg::MODE_W-1:0] mode;
    logic [lgs_pkg::COL_W-1:0]  col;
    logic [lgs_pkg::ROW_W-1:0]  row;
    logic                       value;
  } cell_expect_t;

  cell_expect_t              expected_cells[$];
  logic [MAX_WIDTH-1:0]      board [MAX_HEIGHT];
  logic [lgs_pkg::CFG_W-1:0] width_reg;
  logic [lgs_pkg::CFG_W-1:0] height_reg;
  int                        failures;

  // A size register of zero acts as one, anything past the bound acts as the bound.
  function automatic int active_size(logic [lgs_pkg::CFG_W-1:0] value, int bound);
    if (value == '0) return 1;
    if (int'(value) > bound) return bound;
    return int'(value);
  endfunction

  // One B3/S23 generation over the active area, neighbors wrapping at its edges.
  // On tiny areas the same cell may be counted at several neighbor positions.
  function automatic void advance_board();
    logic [MAX_WIDTH-1:0] old_board [MAX_HEIGHT];
    int w, h, live, rr, cc;
    w = active_size(width_reg, MAX_WIDTH);
    h = active_size(height_reg, MAX_HEIGHT);
    old_board = board;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              rr = (r + h + dr) % h;
              cc = (c + w + dc) % w;
              live += int'(old_board[rr][cc]);
            end
          end
        end
        board[r][c] = old_board[r][c] ? (live == 2 || live == 3) : (live == 3);
      end
    end
  endfunction

  // Applies one request to the mirrored grid and returns the cell value it answers with.
  function automatic logic predict_cell(logic [lgs_pkg::MODE_W-1:0] m,
                                        logic [lgs_pkg::COL_W-1:0] c,
                                        logic [lgs_pkg::ROW_W-1:0] r);
    int w, h;
    w = active_size(width_reg, MAX_WIDTH);
    h = active_size(height_reg, MAX_HEIGHT);
    if (m == lgs_pkg::MODE_STEP) begin
      advance_board();
      return 1'b0;
    end
    if ((m == lgs_pkg::MODE_TOGGLE || m == lgs_pkg::MODE_READ) && int'(c) < w && int'(r) < h)
    begin
      if (m == lgs_pkg::MODE_TOGGLE) board[r][c] = ~board[r][c];
      return board[r][c];
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cell_expect_t want;
    if (rst) begin
      foreach (board[i]) board[i] = '0;
      width_reg  = lgs_pkg::CFG_RESET;
      height_reg = lgs_pkg::CFG_RESET;
      expected_cells.delete();
      failures = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == lgs_pkg::CFG_WIDTH) width_reg = cfg_data;
        else if (cfg_index == lgs_pkg::CFG_HEIGHT) height_reg = cfg_data;
      end
      if (req_valid && !req_stall) begin
        want.mode  = mode;
        want.col   = col;
        want.row   = row;
        want.value = predict_cell(mode, col, row);
        expected_cells.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_cells.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("%0t: response with no request waiting, cell_value %0b", $realtime,
                     cell_value);
          failures++;
        end else begin
          want = expected_cells.pop_front();
          if (cell_value !== want.value) begin
            if (failures < REPORT_LIMIT)
              $display({"%0t: cell_value mismatch for mode %0d col %0d row %0d: ",
                        "expected %0b, got %0b"},
                       $realtime, want.mode, want.col, want.row, want.value, cell_value);
            failures++;
          end
        end
      end
    end
    mismatches  <= failures;
    outstanding <= expected_cells.size();
  end

endmodule

@@ sim/life_grid_generation_step_test.sv @@
// Top of the life grid testbench: clock, reset, request and configuration stimulus, verdict.
module life_grid_generation_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The mode that the block must ignore, and the register indexes it must ignore.
  localparam logic [lgs_pkg::MODE_W-1:0]    MODE_UNUSED      = 2'd3;
  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 2'd2;
  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 2'd3;

  localparam int RESET_CYCLES     = 6;
  localparam int GAP_MAX          = 7;
  localparam int HOLD_OFF_CYCLES  = 240;
  localparam int PHASES           = 10;
  localparam int FIXED_PHASES     = 8;
  localparam int REQUESTS_PER_PHASE = 93;
  // With idling on both sides limited by GAP_MAX and one long hold-off, the slowest run
  // stays far below this bound.
  localparam int CYCLE_LIMIT      = 400_000;

  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          req_valid  = 1'b0;
  logic                          req_stall;
  logic [lgs_pkg::MODE_W-1:0]    mode       = lgs_pkg::MODE_READ;
  logic [lgs_pkg::COL_W-1:0]     col        = '0;
  logic [lgs_pkg::ROW_W-1:0]     row        = '0;
  logic                          rsp_valid;
  logic                          rsp_stall  = 1'b0;
  logic                          cell_value;
  logic                          cfg_write  = 1'b0;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index  = lgs_pkg::CFG_WIDTH;
  logic [lgs_pkg::CFG_W-1:0]     cfg_data   = '0;

  int   mismatches;
  int   outstanding;
  int   cycle_count      = 0;
  int   req_gap_max      = 0;
  int   rsp_gap_max      = 0;
  logic hold_off_request = 1'b0;

  // Active area as the block sees it, used only to aim requests at live regions.
  int   span_w = lgs_pkg::DEF_MAX_WIDTH;
  int   span_h = lgs_pkg::DEF_MAX_HEIGHT;

  // Size settings of the fixed phases; the extremes include zero and values past the bound.
  int   phase_w [FIXED_PHASES] = '{1, 2, 3, 0, 127, 64, 2, 5};
  int   phase_h [FIXED_PHASES] = '{1, 2, 3, 127, 0, 2, 64, 7};

  life_grid_generation_step dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .col        (col),
    .row        (row),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .cell_value (cell_value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  life_grid_checker cell_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .col         (col),
    .row         (row),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .cell_value  (cell_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that has not finished by the cycle limit is a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Response side. Each response waits a random number of stall cycles first. When the
  // stimulus asks for it, one wait is stretched into a long hold-off so that the block
  // holds its response and pushes back on the request side while requests keep coming.
  initial begin : response_sink
    int   pause;
    logic hold_off_done;
    wait (rst == 1'b0);
    hold_off_done = 1'b0;
    forever begin
      pause = $urandom_range(0, rsp_gap_max);
      if (hold_off_request && !hold_off_done) begin
        pause = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (pause > 0) begin
        rsp_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Offers one request after a random gap and holds it steady until the block takes it.
  // Valid stays high into the next request when that one has no gap.
  task automatic send_request(input logic [lgs_pkg::MODE_W-1:0] m, input int c,
                              input int r);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= m;
    col       <= c[lgs_pkg::COL_W-1:0];
    row       <= r[lgs_pkg::ROW_W-1:0];
    do @(posedge clk); while (req_stall);
  endtask

  // Drops valid and waits until every request sent so far has been answered. Every request
  // gets a response, so the block is idle once the count of waiting responses is zero.
  task automatic drain_requests();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes both size registers, preceded by a write to an unused index that must be ignored.
  task automatic write_sizes(input int w, input int h);
    int junk_data;
    junk_data = $urandom_range(0, 127);
    cfg_write <= 1'b1;
    cfg_index <= $urandom_range(0, 1) ? CFG_UNUSED_FIRST : CFG_UNUSED_LAST;
    cfg_data  <= junk_data[lgs_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= lgs_pkg::CFG_WIDTH;
    cfg_data  <= w[lgs_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= lgs_pkg::CFG_HEIGHT;
    cfg_data  <= h[lgs_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    span_w = (w == 0) ? 1 : (w > lgs_pkg::DEF_MAX_WIDTH) ? lgs_pkg::DEF_MAX_WIDTH : w;
    span_h = (h == 0) ? 1 : (h > lgs_pkg::DEF_MAX_HEIGHT) ? lgs_pkg::DEF_MAX_HEIGHT : h;
  endtask

  // Half of the coordinates land anywhere in the active span, the other half in a narrow
  // band around the wrap seam, so that toggles pile up densely across the torus edge and
  // the following steps have something to work on.
  function automatic int pick_coord(int span);
    if ($urandom_range(0, 1)) return $urandom_range(0, span - 1);
    return (2 * span - 2 + $urandom_range(0, 4)) % span;
  endfunction

  // One random request: mostly toggles, reads and steps inside the active area, with some
  // requests anywhere in the full field range and a few of the unused mode.
  task automatic send_random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send_request(lgs_pkg::MODE_TOGGLE, pick_coord(span_w), pick_coord(span_h));
    else if (pick < 63)
      send_request(lgs_pkg::MODE_READ, pick_coord(span_w), pick_coord(span_h));
    else if (pick < 83)
      send_request(lgs_pkg::MODE_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
    else if (pick < 95)
      send_request(pick[0] ? lgs_pkg::MODE_TOGGLE : lgs_pkg::MODE_READ,
                   $urandom_range(0, 63), $urandom_range(0, 63));
    else
      send_request(MODE_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  initial begin : stimulus
    int w, h;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset sizes. Reads of a freshly cleared grid come first, then a
    // blinker laid across the column seam and stepped so that it wraps through row zero.
    send_request(lgs_pkg::MODE_READ, 0, 0);
    send_request(lgs_pkg::MODE_READ, 63, 63);
    send_request(MODE_UNUSED, 63, 63);
    send_request(lgs_pkg::MODE_TOGGLE, 63, 0);
    send_request(lgs_pkg::MODE_TOGGLE, 0, 0);
    send_request(lgs_pkg::MODE_TOGGLE, 1, 0);
    send_request(lgs_pkg::MODE_STEP, 0, 0);
    send_request(lgs_pkg::MODE_READ, 0, 63);
    send_request(lgs_pkg::MODE_READ, 0, 1);
    send_request(lgs_pkg::MODE_READ, 63, 0);
    send_request(lgs_pkg::MODE_STEP, 63, 63);
    send_request(lgs_pkg::MODE_READ, 63, 0);
    // The far corner is flipped on and off again, then the blinker turns once more.
    send_request(lgs_pkg::MODE_TOGGLE, 63, 63);
    send_request(lgs_pkg::MODE_TOGGLE, 63, 63);
    send_request(lgs_pkg::MODE_STEP, 0, 0);
    drain_requests();

    // A small area: requests outside it must change nothing and answer zero, and the cells
    // left outside the area must come through a step untouched.
    write_sizes(3, 3);
    send_request(lgs_pkg::MODE_TOGGLE, 5, 1);
    send_request(lgs_pkg::MODE_READ, 1, 3);
    send_request(lgs_pkg::MODE_TOGGLE, 0, 0);
    send_request(lgs_pkg::MODE_STEP, 0, 0);
    send_request(lgs_pkg::MODE_READ, 0, 0);
    send_request(MODE_UNUSED, 63, 63);
    drain_requests();

    // Random phases, each on its own area size and idle pattern. Every fourth phase, from the
    // first on, runs with no idling; the others idle on the request side, the response side, or both.
    for (int p = 0; p < PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        w = phase_w[p];
        h = phase_h[p];
      end else begin
        w = $urandom_range(0, 127);
        h = $urandom_range(0, 127);
      end
      write_sizes(w, h);
      req_gap_max = (p % 4 == 1 || p % 4 == 3) ? GAP_MAX : 0;
      rsp_gap_max = (p % 4 >= 2) ? GAP_MAX : 0;
      if (p == 5) hold_off_request = 1'b1;
      repeat (REQUESTS_PER_PHASE) send_random_request();
      drain_requests();
    end

    // Everything is answered; give a stray late response time to show up.
    repeat (lgs_pkg::DEF_MAX_HEIGHT + 16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ life_grid_generation_step.f @@
rtl/lgs_pkg.sv
rtl/lgs_cell.sv
rtl/life_grid_generation_step.sv
sim/life_grid_checker.sv
sim/life_grid_generation_step_test.sv
